/* rtl/spg_pkg.sv */
// spg_pkg: shared types, constants and palette functions of the scanline palette ghosting block
// depends on nothing; imported by spg_front, spg_back and the top level
package spg_pkg;

  localparam int unsigned SCHEME_W  = 3;
  localparam int unsigned GHOST_W   = 4;
  localparam int unsigned SCHEMES   = 6;
  localparam int unsigned DIV_STEPS = 12;

  // configuration register indexes
  localparam logic REG_COLOR_SCHEME = 1'b0;
  localparam logic REG_GHOST_FRAMES = 1'b1;

  typedef struct packed {
    logic [SCHEME_W-1:0] scheme;
    logic [GHOST_W-1:0]  ghost;
  } spg_cfg_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_MERGE,
    BK_SEARCH,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } spg_state_t;

  // six palettes, four colors of r, g, b
  localparam logic [7:0] PAL [0:5][0:11] = '{
    '{8'd252, 8'd252, 8'd252, 8'd168, 8'd168, 8'd168,
      8'd84,  8'd84,  8'd84,  8'd0,   8'd0,   8'd0},
    '{8'd252, 8'd154, 8'd0,   8'd168, 8'd102, 8'd0,
      8'd84,  8'd51,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd50,  8'd227, 8'd50,  8'd34,  8'd151, 8'd34,
      8'd17,  8'd76,  8'd17,  8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd154, 8'd252, 8'd0,   8'd102, 8'd168,
      8'd0,   8'd51,  8'd84,  8'd0,   8'd0,   8'd0},
    '{8'd224, 8'd248, 8'd208, 8'd136, 8'd192, 8'd112,
      8'd52,  8'd104, 8'd86,  8'd8,   8'd24,  8'd32},
    '{8'h7b,  8'hc7,  8'h7b,  8'h52,  8'ha6,  8'h8c,
      8'h2e,  8'h62,  8'h60,  8'h0d,  8'h32,  8'h2e}
  };

  localparam logic [15:0] OPAQUE = 16'h8000;

  function automatic logic [7:0] pal_ch(input logic [SCHEME_W-1:0] scheme,
                                        input logic [1:0] code,
                                        input logic [1:0] ch);
    logic [3:0] idx;
    idx = 4'(code) * 4'd3 + 4'(ch);
    return PAL[scheme][idx];
  endfunction

  function automatic logic [15:0] pack555(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return OPAQUE | {1'b0, b[7:3], g[7:3], r[7:3]};
  endfunction

  function automatic logic [15:0] plain_color(input logic [SCHEME_W-1:0] scheme,
                                              input logic [1:0] code);
    return pack555(pal_ch(scheme, code, 2'd0), pal_ch(scheme, code, 2'd1),
                   pal_ch(scheme, code, 2'd2));
  endfunction

endpackage

/* rtl/spg_ram.sv */
// spg_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module spg_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 25600
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/spg_fifo.sv */
// spg_fifo: two-entry word queue, used between front and back and on the result side
// depends on nothing
module spg_fifo #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) begin
        wptr <= ~wptr;
      end
      if (rd && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr && !full) - 2'(rd && !empty);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

/* rtl/spg_front.sv */
// spg_front: configuration registers, line and frame tracking, history address of each word
// depends on spg_pkg
module spg_front #(
  parameter int unsigned LINE_WIDTH = 160,
  parameter int unsigned LINE_COUNT = 160,
  parameter int unsigned GHOST_MAX  = 8,
  parameter int unsigned AW         = 15,
  parameter int unsigned SW         = 4,
  parameter int unsigned IW         = 22
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              write_enable,
  input  logic              write_index,
  input  logic [3:0]        write_data,
  input  logic              accept,
  input  logic [1:0]        pixel_code,
  input  logic [7:0]        column,
  input  logic              line_end,
  output logic [IW-1:0]     item,
  output spg_pkg::spg_cfg_t cfg,
  output logic              clear_req
);
  import spg_pkg::*;

  localparam int unsigned SLOT_COUNT = GHOST_MAX + 1;
  localparam int unsigned LNW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

  logic [SW-1:0]  slot;
  logic [LNW-1:0] line;
  logic           in_range;
  logic           rec;
  logic [AW-1:0]  addr;

  assign in_range  = ({1'b0, column} < 9'(LINE_WIDTH));
  assign rec       = (cfg.ghost != '0) && in_range;
  assign addr      = AW'(line) * AW'(LINE_WIDTH) + AW'(column);
  assign item      = {pixel_code, addr, slot, rec};
  assign clear_req = write_enable && (write_index == REG_GHOST_FRAMES);

  // configuration writes, bad palettes ignored and ghost count clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (write_enable) begin
      if (write_index == REG_COLOR_SCHEME) begin
        if (write_data[2:0] < 3'(SCHEMES)) begin
          cfg.scheme <= write_data[2:0];
        end
      end else begin
        cfg.ghost <= (write_data > 4'(GHOST_MAX)) ? 4'(GHOST_MAX) : write_data;
      end
    end
  end

  // line and frame slot advance on line end while ghosting
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      line <= '0;
    end else if (accept && line_end && (cfg.ghost != '0)) begin
      if (line == LNW'(LINE_COUNT - 1)) begin
        line <= '0;
        slot <= (slot == SW'(SLOT_COUNT - 1)) ? '0 : slot + 1'b1;
      end else begin
        line <= line + 1'b1;
      end
    end
  end

endmodule

/* rtl/spg_back.sv */
// spg_back: history read-modify-write, newest-first search, fade divider and result push
// depends on spg_pkg and spg_ram
module spg_back #(
  parameter int unsigned LINE_WIDTH = 160,
  parameter int unsigned LINE_COUNT = 160,
  parameter int unsigned GHOST_MAX  = 8,
  parameter int unsigned AW         = 15,
  parameter int unsigned SW         = 4,
  parameter int unsigned IW         = 22
) (
  input  logic              clk,
  input  logic              rst,
  input  spg_pkg::spg_cfg_t cfg,
  input  logic              clear_req,
  input  logic [IW-1:0]     item,
  input  logic              item_empty,
  output logic              item_pop,
  output logic              clearing,
  input  logic              out_full,
  output logic              out_push,
  output logic [15:0]       color
);
  import spg_pkg::*;

  localparam int unsigned SLOT_COUNT = GHOST_MAX + 1;
  localparam int unsigned RW         = 2 * SLOT_COUNT;
  localparam int unsigned DEPTH      = LINE_WIDTH * LINE_COUNT;

  spg_state_t state, state_next;

  logic [1:0]    it_code;
  logic [AW-1:0] it_addr;
  logic [SW-1:0] it_slot;
  logic [RW-1:0] row;
  logic [SW-1:0] ptr;
  logic [3:0]    age;
  logic [3:0]    step;
  logic [AW-1:0] clr_addr;
  logic [1:0]    fld;

  logic [7:0]    ch_v [3];
  logic          neg  [3];
  logic [11:0]   num  [3];
  logic [3:0]    rem  [3];

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [RW-1:0] ram_rdata;
  logic [RW-1:0] merged;

  spg_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (it_addr),
    .rdata (ram_rdata)
  );

  assign fld = row[{ptr, 1'b0} +: 2];

  // current code placed into its frame slot of the row
  always_comb begin
    merged = ram_rdata;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (SW'(i) == it_slot) begin
        merged[2*i +: 2] = it_code;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if ((clr_addr == AW'(DEPTH - 1)) && !clear_req) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (clear_req) begin
          state_next = BK_CLEAR;
        end else if (!item_empty) begin
          state_next = item[0] ? BK_READ : BK_OUT;
        end
      end
      BK_READ:   state_next = BK_MERGE;
      BK_MERGE:  state_next = (it_code != 2'd0) ? BK_OUT : BK_SEARCH;
      BK_SEARCH: begin
        if (fld != 2'd0) begin
          state_next = BK_DIV;
        end else if (age == cfg.ghost - 4'd1) begin
          state_next = BK_OUT;
        end
      end
      BK_DIV:    if (step == 4'(DIV_STEPS - 1)) state_next = BK_FIN;
      BK_FIN:    state_next = BK_OUT;
      BK_OUT:    if (!out_full) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_pop  = 1'b0;
    out_push  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = it_addr;
    ram_wdata = merged;
    clearing  = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      BK_IDLE:   item_pop = !item_empty && !clear_req;
      BK_READ:   ram_re = 1'b1;
      BK_MERGE:  ram_we = 1'b1;
      BK_OUT:    out_push = !out_full;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst || clear_req) begin
      clr_addr <= '0;
    end else if (state == BK_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        {it_code, it_addr, it_slot} <= item[IW-1:1];
        color <= plain_color(cfg.scheme, item[IW-1 -: 2]);
      end
      BK_MERGE: begin
        row <= ram_rdata;
        ptr <= (it_slot == '0) ? SW'(SLOT_COUNT - 1) : it_slot - 1'b1;
        age <= 4'd0;
      end
      BK_SEARCH: begin
        step <= 4'd0;
        if (fld != 2'd0) begin
          for (int i = 0; i < 3; i++) begin
            ch_v[i] <= pal_ch(cfg.scheme, fld, 2'(i));
            neg[i]  <= pal_ch(cfg.scheme, 2'd0, 2'(i)) < pal_ch(cfg.scheme, fld, 2'(i));
            num[i]  <= 12'(((pal_ch(cfg.scheme, 2'd0, 2'(i)) < pal_ch(cfg.scheme, fld, 2'(i)))
                           ? pal_ch(cfg.scheme, fld, 2'(i)) - pal_ch(cfg.scheme, 2'd0, 2'(i))
                           : pal_ch(cfg.scheme, 2'd0, 2'(i)) - pal_ch(cfg.scheme, fld, 2'(i)))
                           * age);
            rem[i]  <= 4'd0;
          end
        end else begin
          age <= age + 4'd1;
          ptr <= (ptr == '0) ? SW'(SLOT_COUNT - 1) : ptr - 1'b1;
        end
      end
      BK_DIV: begin
        // one restoring step per lane, quotient shifts into num
        step <= step + 4'd1;
        for (int i = 0; i < 3; i++) begin
          if ({rem[i], num[i][11]} >= {1'b0, cfg.ghost}) begin
            rem[i] <= 4'({rem[i], num[i][11]} - {1'b0, cfg.ghost});
            num[i] <= {num[i][10:0], 1'b1};
          end else begin
            rem[i] <= {rem[i][2:0], num[i][11]};
            num[i] <= {num[i][10:0], 1'b0};
          end
        end
      end
      BK_FIN: begin
        color <= pack555(neg[0] ? ch_v[0] - num[0][7:0] : ch_v[0] + num[0][7:0],
                         neg[1] ? ch_v[1] - num[1][7:0] : ch_v[1] + num[1][7:0],
                         neg[2] ? ch_v[2] - num[2][7:0] : ch_v[2] + num[2][7:0]);
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/scanline_palette_ghosting.sv */
// scanline_palette_ghosting: top level joining front, item queue, back and result queue
// depends on spg_pkg, spg_front, spg_fifo, spg_back
//
// usage:
//   input words (pixel_code, column, line_end) enter on push while full is low;
//   each gives exactly one pixel_color word, shown while empty is low and taken
//   with pop. words come out in input order.
//   configuration: write_enable with write_index 0 (color_scheme) or
//   1 (ghost_frames) and write_data; write only when the block is idle.
//   a plain word (ghosting off or column outside the line) goes straight to
//   the result; a recorded word first passes the history read-modify-write;
//   a recorded zero code then searches the older frames newest first (up to
//   ghost_frames) and, on a hit, fades the found color (12 divider steps and a
//   final add). the back works on one word at a time and takes no new word
//   until the last one is pushed.
//   reset, and every write to ghost_frames, start a clearing pass over the
//   LINE_WIDTH*LINE_COUNT words of the history ram (25600 at defaults),
//   during which full stays high.
//   when the receiver stalls, two results wait in the result queue, one in the
//   back and two words in the item queue, then full rises.
module scanline_palette_ghosting #(
  parameter int unsigned LINE_WIDTH = 160,
  parameter int unsigned LINE_COUNT = 160,
  parameter int unsigned GHOST_MAX  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic        write_index,
  input  logic [3:0]  write_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  pixel_code,
  input  logic [7:0]  column,
  input  logic        line_end,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] pixel_color
);
  import spg_pkg::*;

  localparam int unsigned AW = $clog2(LINE_WIDTH * LINE_COUNT);
  localparam int unsigned SW = $clog2(GHOST_MAX + 1);
  localparam int unsigned IW = 2 + AW + SW + 1;

  spg_cfg_t      cfg;
  logic          clear_req;
  logic          clearing;
  logic          accept;
  logic [IW-1:0] item_in;
  logic [IW-1:0] item_out;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          out_full;
  logic          out_push;
  logic [15:0]   color;

  assign full   = q_full || clearing;
  assign accept = push && !full;

  spg_front #(.LINE_WIDTH(LINE_WIDTH), .LINE_COUNT(LINE_COUNT), .GHOST_MAX(GHOST_MAX),
              .AW(AW), .SW(SW), .IW(IW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .accept       (accept),
    .pixel_code   (pixel_code),
    .column       (column),
    .line_end     (line_end),
    .item         (item_in),
    .cfg          (cfg),
    .clear_req    (clear_req)
  );

  // item queue between front and back
  spg_fifo #(.WIDTH(IW)) u_itemq (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept),
    .wdata (item_in),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (item_out),
    .empty (q_empty)
  );

  spg_back #(.LINE_WIDTH(LINE_WIDTH), .LINE_COUNT(LINE_COUNT), .GHOST_MAX(GHOST_MAX),
             .AW(AW), .SW(SW), .IW(IW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clear_req  (clear_req),
    .item       (item_out),
    .item_empty (q_empty),
    .item_pop   (q_pop),
    .clearing   (clearing),
    .out_full   (out_full),
    .out_push   (out_push),
    .color      (color)
  );

  // result queue
  spg_fifo #(.WIDTH(16)) u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_push),
    .wdata (color),
    .full  (out_full),
    .rd    (pop),
    .rdata (pixel_color),
    .empty (empty)
  );

endmodule

/* rtl/spg_checker.sv */
// spg_checker: port-level assertions of the scanline palette ghosting block, bound to the top
// depends on scanline_palette_ghosting
module spg_checker (
  input logic        clk,
  input logic        rst,
  input logic        write_enable,
  input logic        write_index,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] pixel_color
);

  // reset leaves no result and starts the history clear
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");
  a_rst_full: assert property (@(posedge clk) rst |=> full)
    else $error("input open during history clear");

  // a ghost_frames write starts a clear
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    (write_enable && write_index) |=> full)
    else $error("input open after ghost_frames write");

  // every shown color is opaque
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pixel_color[15])
    else $error("color without bit 15");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_color)))
    else $error("waiting result changed");

endmodule

bind scanline_palette_ghosting spg_checker u_spg_checker (.*);
